// ===== sv/wed_pkg.sv =====
// shared constants, types and helper functions for the weighted edit distance core
package wed_pkg;

  // store capacity and derived widths
  localparam int MAX_CHARS = 256;
  localparam int CNT_W     = $clog2(MAX_CHARS + 1);
  localparam int ADDR_W    = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;

  // field widths
  localparam int SYM_W   = 21;
  localparam int DIST_W  = 18;
  localparam int COST_W  = 8;
  localparam int BOUND_W = 19;
  localparam int CMD_W   = 2;
  localparam int PROD_W  = CNT_W + COST_W;

  // stream bus widths
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;
  localparam int IN_USER_W  = 2;
  localparam int OUT_USER_W = 2;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // request commands
  localparam logic [CMD_W-1:0] CMD_SOURCE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TARGET = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FINISH = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic load_src;
    logic set_ovf;
    logic count_tgt;
    logic start_row;
    logic rd_en;
    logic fin_calc;
    logic fin_out;
  } wed_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic src_zero;
    logic tgt_zero;
    logic src_full;
    logic tgt_full;
    logic last_rd;
    logic out_busy;
  } wed_stat_t;

  // saturating add of a distance and a distance
  function automatic logic [DIST_W-1:0] sat_add(input logic [DIST_W-1:0] a,
                                                input logic [DIST_W-1:0] b);
    logic [DIST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DIST_W] ? DIST_MAX : s[DIST_W-1:0];
  endfunction

  // saturating add of a distance and a cost
  function automatic logic [DIST_W-1:0] sat_add_cost(input logic [DIST_W-1:0] a,
                                                     input logic [COST_W-1:0] c);
    return sat_add(a, {{(DIST_W-COST_W){1'b0}}, c});
  endfunction

endpackage

// ===== sv/wed_ctrl.sv =====
// controller state machine for the weighted edit distance core
module wed_ctrl
  import wed_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [CMD_W-1:0] in_cmd,
  output logic             in_ready,
  input  wed_stat_t        stat,
  output wed_cmd_t         cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_ROW      = 3'd1;
  localparam logic [2:0] S_DRAIN    = 3'd2;
  localparam logic [2:0] S_FIN_CALC = 3'd3;
  localparam logic [2:0] S_FIN_OUT  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // next state and command decode
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_cmd)
            CMD_SOURCE: begin
              if (stat.tgt_zero) begin
                if (stat.src_full) cmd.set_ovf = 1'b1;
                else cmd.load_src = 1'b1;
              end
            end
            CMD_TARGET: begin
              if (stat.tgt_full) begin
                cmd.set_ovf = 1'b1;
              end else begin
                cmd.count_tgt = 1'b1;
                if (!stat.src_zero) begin
                  cmd.start_row = 1'b1;
                  state_nxt     = S_ROW;
                end
              end
            end
            CMD_FINISH: state_nxt = S_FIN_CALC;
            default: ;
          endcase
        end
      end
      S_ROW: begin
        cmd.rd_en = 1'b1;
        if (stat.last_rd) state_nxt = S_DRAIN;
      end
      S_DRAIN: state_nxt = S_IDLE;
      S_FIN_CALC: begin
        cmd.fin_calc = 1'b1;
        state_nxt    = S_FIN_OUT;
      end
      S_FIN_OUT: begin
        if (!stat.out_busy) begin
          cmd.fin_out = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/wed_datapath.sv =====
// stores, row recurrence cell and result register of the weighted edit distance core
module wed_datapath
  import wed_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [SYM_W-1:0]          in_sym,
  input  logic [COST_W-1:0]         ins_cost,
  input  logic [COST_W-1:0]         del_cost,
  input  logic [COST_W-1:0]         sub_cost,
  input  logic signed [BOUND_W-1:0] bound,
  input  wed_cmd_t                  cmd,
  output wed_stat_t                 stat,
  input  logic                      out_ready,
  output logic                      out_valid,
  output logic [DIST_W-1:0]         out_dist,
  output logic                      out_exceeded,
  output logic                      out_status
);

  // memories
  logic [SYM_W-1:0]  src_mem [MAX_CHARS];
  logic [DIST_W-1:0] row_mem [MAX_CHARS];

  // counters and control state
  logic [CNT_W-1:0]  src_cnt_r, tgt_cnt_r;
  logic              ovf_r;
  logic [DIST_W-1:0] row0_r;
  logic [ADDR_W-1:0] j_r;
  logic              rd_v_r;
  logic [ADDR_W-1:0] wr_addr_r;
  logic              out_valid_r;

  // payload registers
  logic [SYM_W-1:0]  sym_r;
  logic              first_r;
  logic [DIST_W-1:0] left_r, diag_r, init_acc_r;
  logic [SYM_W-1:0]  src_rd_r;
  logic [DIST_W-1:0] row_rd_r;
  logic [DIST_W-1:0] prod_r;
  logic [DIST_W-1:0] out_dist_r;
  logic              out_exc_r, out_stat_r;

  // cell logic
  logic [DIST_W-1:0] init_above, above, ins_v, del_v, sub_v, best;
  logic [DIST_W-1:0] row0_nxt;

  // finish logic
  logic [CNT_W-1:0]        mul_cnt;
  logic [COST_W-1:0]       mul_cost;
  logic [PROD_W-1:0]       prod;
  logic [DIST_W-1:0]       prod_sat;
  logic [DIST_W-1:0]       fin_d, fin_d_nxt;
  logic                    fin_exc, bound_set;
  logic [DIST_W-1:0]       bound_mag;
  logic [CNT_W-1:0]        last_idx;

  // status to controller
  assign last_idx       = src_cnt_r - 1'b1;
  assign stat.src_zero  = (src_cnt_r == '0);
  assign stat.tgt_zero  = (tgt_cnt_r == '0);
  assign stat.src_full  = (src_cnt_r == CNT_W'(MAX_CHARS));
  assign stat.tgt_full  = (tgt_cnt_r == CNT_W'(MAX_CHARS));
  assign stat.last_rd   = ({{(CNT_W-ADDR_W){1'b0}}, j_r} == last_idx);
  assign stat.out_busy  = out_valid_r && !out_ready;

  // one cell of the recurrence, first row above comes from cumulative delete cost
  assign init_above = sat_add_cost(init_acc_r, del_cost);
  assign above      = first_r ? init_above : row_rd_r;
  assign ins_v      = sat_add_cost(above, ins_cost);
  assign del_v      = sat_add_cost(left_r, del_cost);
  assign sub_v      = (src_rd_r != sym_r) ? sat_add_cost(diag_r, sub_cost) : diag_r;

  always_comb begin
    best = (ins_v < del_v) ? ins_v : del_v;
    if (sub_v < best) best = sub_v;
  end

  assign row0_nxt = sat_add_cost(row0_r, ins_cost);

  // source store write and read
  always_ff @(posedge clk) begin
    if (cmd.load_src) src_mem[src_cnt_r[ADDR_W-1:0]] <= in_sym;
    if (cmd.rd_en) src_rd_r <= src_mem[j_r];
  end

  // row store write and read
  always_ff @(posedge clk) begin
    if (rd_v_r) row_mem[wr_addr_r] <= best;
    if (cmd.rd_en) row_rd_r <= row_mem[j_r];
  end

  // empty-string product, saturated
  assign mul_cnt  = stat.src_zero ? tgt_cnt_r : src_cnt_r;
  assign mul_cost = stat.src_zero ? ins_cost : del_cost;
  assign prod     = {{COST_W{1'b0}}, mul_cnt} * {{CNT_W{1'b0}}, mul_cost};
  assign prod_sat = ({{DIST_W{1'b0}}, prod} > {{PROD_W{1'b0}}, DIST_MAX}) ?
                    DIST_MAX : DIST_W'(prod);

  // bound check on the final distance
  assign bound_set = !bound[BOUND_W-1];
  assign bound_mag = bound[DIST_W-1:0];
  assign fin_d     = (stat.src_zero || stat.tgt_zero) ? prod_r : left_r;

  always_comb begin
    fin_exc   = 1'b0;
    fin_d_nxt = fin_d;
    if (ovf_r) begin
      fin_d_nxt = '0;
    end else if (bound_set && (fin_d > bound_mag)) begin
      fin_exc = 1'b1;
      if (!stat.src_zero && !stat.tgt_zero) fin_d_nxt = bound_mag + 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_cnt_r   <= '0;
      tgt_cnt_r   <= '0;
      ovf_r       <= 1'b0;
      row0_r      <= '0;
      j_r         <= '0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_v_r <= cmd.rd_en;
      if (cmd.load_src) src_cnt_r <= src_cnt_r + 1'b1;
      if (cmd.count_tgt) tgt_cnt_r <= tgt_cnt_r + 1'b1;
      if (cmd.set_ovf) ovf_r <= 1'b1;
      if (cmd.start_row) begin
        row0_r <= row0_nxt;
        j_r    <= '0;
      end else if (cmd.rd_en) begin
        j_r <= j_r + 1'b1;
      end
      if (cmd.fin_out) begin
        out_valid_r <= 1'b1;
        src_cnt_r   <= '0;
        tgt_cnt_r   <= '0;
        ovf_r       <= 1'b0;
        row0_r      <= '0;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.start_row) begin
      sym_r      <= in_sym;
      first_r    <= stat.tgt_zero;
      diag_r     <= row0_r;
      left_r     <= row0_nxt;
      init_acc_r <= '0;
    end else if (rd_v_r) begin
      left_r     <= best;
      diag_r     <= above;
      init_acc_r <= init_above;
    end
    wr_addr_r <= j_r;
    if (cmd.fin_calc) prod_r <= prod_sat;
    if (cmd.fin_out) begin
      out_dist_r <= fin_d_nxt;
      out_exc_r  <= fin_exc;
      out_stat_r <= ovf_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_dist     = out_dist_r;
  assign out_exceeded = out_exc_r;
  assign out_status   = out_stat_r;

endmodule

// ===== sv/weighted_edit_distance_core.sv =====
// top level of the weighted edit distance core: config registers, controller and datapath
//
//  channel | direction | handshake             | payload
//  in_     | input     | in_tvalid / in_tready  | tdata symbol, tuser command
//  out_    | output    | out_tvalid / out_tready| tdata distance, tuser flags
//  cfg_    | input     | psel, penable, pready  | four cost and bound registers
//
// source, unused and dropped requests leave the input open; a target request with m stored
// source characters runs the row state, one row cell per cycle through the row store port,
// then drain; a finish request computes, then waits while the output register is occupied
// reset is synchronous and clears counts and flags; no clearing pass of the stores
// the output register holds a result while out_tready is low; in_tready drops while busy
module weighted_edit_distance_core
  import wed_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [20:0] symbol
  input  logic [IN_USER_W-1:0]  in_tuser,   // [1:0] command
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [17:0] distance
  output logic [OUT_USER_W-1:0] out_tuser,  // [0] bound_exceeded, [1] status
  // configuration
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [3:0]            cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  localparam logic [3:0] ADDR_INS   = 4'h0;
  localparam logic [3:0] ADDR_DEL   = 4'h4;
  localparam logic [3:0] ADDR_SUB   = 4'h8;
  localparam logic [3:0] ADDR_BOUND = 4'hC;

  logic [COST_W-1:0]         ins_cost_r, del_cost_r, sub_cost_r;
  logic signed [BOUND_W-1:0] bound_r;
  logic                      cfg_wr;

  wed_cmd_t          cmd;
  wed_stat_t         stat;
  logic [DIST_W-1:0] dist_val;
  logic              exceeded, status;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // configuration register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ins_cost_r <= COST_W'(1);
      del_cost_r <= COST_W'(1);
      sub_cost_r <= COST_W'(1);
      bound_r    <= '1;
    end else if (cfg_wr) begin
      unique case (cfg_paddr)
        ADDR_INS:   ins_cost_r <= cfg_pwdata[COST_W-1:0];
        ADDR_DEL:   del_cost_r <= cfg_pwdata[COST_W-1:0];
        ADDR_SUB:   sub_cost_r <= cfg_pwdata[COST_W-1:0];
        ADDR_BOUND: bound_r    <= cfg_pwdata[BOUND_W-1:0];
        default: ;
      endcase
    end
  end

  // configuration readback
  always_comb begin
    unique case (cfg_paddr)
      ADDR_INS:   cfg_prdata = {{(32-COST_W){1'b0}}, ins_cost_r};
      ADDR_DEL:   cfg_prdata = {{(32-COST_W){1'b0}}, del_cost_r};
      ADDR_SUB:   cfg_prdata = {{(32-COST_W){1'b0}}, sub_cost_r};
      ADDR_BOUND: cfg_prdata = {{(32-BOUND_W){bound_r[BOUND_W-1]}}, bound_r};
      default:    cfg_prdata = '0;
    endcase
  end

  wed_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_cmd   (in_tuser[CMD_W-1:0]),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  wed_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_sym       (in_tdata[SYM_W-1:0]),
    .ins_cost     (ins_cost_r),
    .del_cost     (del_cost_r),
    .sub_cost     (sub_cost_r),
    .bound        (bound_r),
    .cmd          (cmd),
    .stat         (stat),
    .out_ready    (out_tready),
    .out_valid    (out_tvalid),
    .out_dist     (dist_val),
    .out_exceeded (exceeded),
    .out_status   (status)
  );

  // result packing
  assign out_tdata = {{(OUT_DATA_W-DIST_W){1'b0}}, dist_val};
  assign out_tuser = {status, exceeded};

endmodule

// ===== sv/wed_checker.sv =====
// port-level assertions for the weighted edit distance core and their bind
module wed_checker
  import wed_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [IN_USER_W-1:0]  in_tuser,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [OUT_USER_W-1:0] out_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // an overflow result carries no distance and no bound flag
  a_ovf_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tdata == '0 && !out_tuser[0])
    else $error("overflow result with nonzero distance or bound flag");

  // a finish request keeps the input closed while the result is formed
  a_finish_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == CMD_FINISH |=> !in_tready)
    else $error("input open right after a finish request");

  // padding bits above the distance stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_DATA_W-1:DIST_W] == '0)
    else $error("nonzero padding in result data");

endmodule

bind weighted_edit_distance_core wed_checker u_wed_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
